>>> src/time_slot_reservation_checker_core_macros.svh
// Assertion macros for the time slot reservation checker.
// Used by the top level only; expects signals clk and arst_n in scope.
`ifndef TIME_SLOT_RESERVATION_CHECKER_CORE_MACROS_SVH
`define TIME_SLOT_RESERVATION_CHECKER_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define TSRC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define TSRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/tsrc_pkg.sv
// Shared constants for the time slot reservation checker.
// No dependencies; imported by tsrc_ram and the top level.
package tsrc_pkg;

	localparam int FIELD_W     = 21;       // width of the slot and period fields
	localparam int OP_W        = 2;
	localparam int HORIZON_DEF = 1048576;  // default number of time slots
	localparam int WORD_W      = 32;       // slots held in one memory word
	localparam int WORD_LSB    = 5;        // log2 of WORD_W

	localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
	localparam logic [OP_W-1:0] OP_ONESHOT  = 2'd1;
	localparam logic [OP_W-1:0] OP_PERIODIC = 2'd2;

endpackage

>>> src/tsrc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on tsrc_pkg for the default word width.
module tsrc_ram #(
	parameter int WIDTH = tsrc_pkg::WORD_W,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	import tsrc_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/time_slot_reservation_checker_core.sv
// Top level of the time slot reservation checker: sequencer and occupancy memory.
// Depends on tsrc_pkg, tsrc_ram and time_slot_reservation_checker_core_macros.svh.
`include "time_slot_reservation_checker_core_macros.svh"

// Time slot reservation checker. Keeps a one-bit occupancy map over HORIZON
// slots in a RAM of 32-slot words, plus a sticky conflict flag. Each input
// transaction (clear, one-shot task, periodic task) yields exactly one output
// transaction carrying the flag. After reset the block runs a clearing pass over
// all ceil(HORIZON/32) words (32768 at the default horizon) with in_ready low.
// Work per transaction, set by the read-modify-write loop on the map RAM:
// a clear writes every map word, one word written per cycle; a task visits
// each 32-slot word it touches with a read step, then a check and write-back
// step, plus a step to move on to each further repetition. A task arriving
// while the flag is up, or an unused code, goes straight to ST_FIN. A new transaction
// is taken while the previous result still waits in the output register; its
// own result then holds in ST_FIN until that one has been taken.
module time_slot_reservation_checker_core #(
	parameter int HORIZON = tsrc_pkg::HORIZON_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tsrc_pkg::OP_W-1:0]    operation,
	input  logic [tsrc_pkg::FIELD_W-1:0] interval_start,
	input  logic [tsrc_pkg::FIELD_W-1:0] interval_end,
	input  logic [tsrc_pkg::FIELD_W-1:0] repeat_period,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         conflict
);
	import tsrc_pkg::*;

	localparam int DEPTH  = (HORIZON + WORD_W - 1) / WORD_W;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// slot positions: repetition ends can run up to HORIZON + 2^FIELD_W
	localparam int POS_W  = $clog2(HORIZON + 2 ** (FIELD_W + 1));
	localparam int WRD_W  = POS_W - WORD_LSB;
	localparam logic [POS_W-1:0]  HORIZON_P = POS_W'(HORIZON);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	typedef enum logic [2:0] {
		ST_INIT,   // clearing pass after reset
		ST_IDLE,
		ST_CLEAR,  // clearing pass for a clear transaction
		ST_REP,    // issue read for current word, or step to next repetition
		ST_CHK,    // read data back: test, then write the marked word
		ST_FIN     // hand the flag to the output register
	} state_t;

	state_t              state_q;
	logic [POS_W-1:0]    lo_q;        // start of current repetition
	logic [POS_W-1:0]    hi_q;        // end of current repetition, unclamped
	logic [POS_W-1:0]    cur_q;       // next slot to mark
	logic [FIELD_W-1:0]  period_q;
	logic                periodic_q;
	logic                flag_q;      // sticky conflict
	logic [ADDR_W-1:0]   clr_addr_q;
	logic                out_valid_q;
	logic                conflict_q;

	logic [POS_W-1:0]    hi_c;
	logic [WRD_W-1:0]    cur_word;
	logic [WRD_W-1:0]    hi_word;
	logic [POS_W-1:0]    next_cur;
	logic [POS_W-1:0]    lo_next;
	logic [POS_W-1:0]    hi_next;
	logic                can_repeat;
	logic [WORD_W-1:0]   lo_mask;
	logic [WORD_W-1:0]   hi_mask;
	logic [WORD_W-1:0]   mark_mask;
	logic                hit;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [WORD_W-1:0]   ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [WORD_W-1:0]   ram_rdata;

	// end of the repetition, clamped to the horizon
	assign hi_c     = (hi_q > HORIZON_P) ? HORIZON_P : hi_q;
	assign cur_word = cur_q[POS_W-1:WORD_LSB];
	assign hi_word  = hi_c[POS_W-1:WORD_LSB];
	assign next_cur = {WRD_W'(cur_word + 1'b1), {WORD_LSB{1'b0}}};

	assign lo_next    = lo_q + POS_W'(period_q);
	assign hi_next    = hi_q + POS_W'(period_q);
	assign can_repeat = periodic_q && (period_q != '0) && (lo_next <= HORIZON_P);

	// slots of this word inside [cur, hi_c)
	assign lo_mask   = {WORD_W{1'b1}} << cur_q[WORD_LSB-1:0];
	assign hi_mask   = (hi_word == cur_word)
		? ((WORD_W'(1) << hi_c[WORD_LSB-1:0]) - WORD_W'(1))
		: {WORD_W{1'b1}};
	assign mark_mask = lo_mask & hi_mask;
	assign hit       = |(ram_rdata & mark_mask);

	// Map RAM. The write of a word (end of ST_CHK) always lands before the
	// next read is taken (end of ST_REP), so no forwarding needed.
	always_comb begin
		ram_raddr = cur_word[ADDR_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = cur_word[ADDR_W-1:0];
		ram_wdata = ram_rdata | mark_mask;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			ST_CHK: begin
				ram_we = !hit;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	tsrc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign conflict  = conflict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			lo_q        <= '0;
			hi_q        <= '0;
			cur_q       <= '0;
			period_q    <= '0;
			periodic_q  <= 1'b0;
			flag_q      <= 1'b0;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			conflict_q  <= 1'b0;
		end else begin
			// ST_FIN owns the output register in its own cycle
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						lo_q       <= POS_W'(interval_start);
						cur_q      <= POS_W'(interval_start);
						hi_q       <= POS_W'(interval_end);
						period_q   <= repeat_period;
						periodic_q <= (operation == OP_PERIODIC);
						case (operation) inside
							OP_CLEAR: begin
								flag_q     <= 1'b0;
								clr_addr_q <= '0;
								state_q    <= ST_CLEAR;
							end
							OP_ONESHOT, OP_PERIODIC: begin
								// tasks are ignored while the flag is up
								state_q <= flag_q ? ST_FIN : ST_REP;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_FIN;
					end
				end
				ST_REP: begin
					if (cur_q < hi_c) begin
						state_q <= ST_CHK;
					end else if (can_repeat) begin
						lo_q  <= lo_next;
						cur_q <= lo_next;
						hi_q  <= hi_next;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_CHK: begin
					if (hit) begin
						// map left part-marked: unseen until the next clear
						flag_q  <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						cur_q   <= next_cur;
						state_q <= ST_REP;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						conflict_q  <= flag_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// marking only ever happens with the flag down
	`TSRC_ASSERT_NOW(a_mark_flag_low, (state_q == ST_CHK) && ram_we, !flag_q,
		"map written while conflict flag is up")
	// every RAM write stays inside the map
	`TSRC_ASSERT_NOW(a_waddr_range, ram_we, ram_waddr <= LAST_ADDR,
		"map write address beyond last word")
	// a taken result is not shown again unless a new one is loaded
	`TSRC_ASSERT_NEXT(a_out_once, out_valid && out_ready && (state_q != ST_FIN),
		!out_valid, "result repeated after hand-over")

endmodule
